[sv/cle_pkg.sv]
// ----------------------------------------------------------------------------
// Console line editor package
// Shared types and key codes for the canonical-mode console input buffer.
// ----------------------------------------------------------------------------
package cle_pkg;

	localparam int BUF_DEPTH_DEF = 128;

	localparam logic [7:0] KEY_KILL = 8'h15;
	localparam logic [7:0] KEY_BS   = 8'h08;
	localparam logic [7:0] KEY_DEL  = 8'h7F;
	localparam logic [7:0] KEY_EOF  = 8'h04;
	localparam logic [7:0] KEY_CR   = 8'h0D;
	localparam logic [7:0] KEY_LF   = 8'h0A;

	localparam logic OP_RECV    = 1'b0;
	localparam logic OP_CONSUME = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] ch;
	} req_t;

	typedef struct packed {
		logic       echo_valid;
		logic [7:0] echo_char;
		logic [7:0] erase_count;
		logic       line_ready;
		logic       read_valid;
		logic [7:0] read_byte;
		logic       read_end;
	} rsp_t;

endpackage

[sv/console_line_editor_top.sv]
// A received byte or an erase passes through S_RESULT into the response register; a consume request
// that takes a byte passes through S_CONS and then S_RESULT, an empty one through S_RESULT alone;
// a kill-line passes through S_KILL_RD, S_KILL_CMP per examined byte, then S_RESULT. Only S_IDLE takes a request.
// Kill-line walks back one stored byte per cycle, set by the single read port of the line store.
// Reset clears the positions and the sequencer and sets cr_to_lf to 1;
// the line store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// Console line editor
// Canonical-mode console input buffer with line editing and a committed-byte
// read path, built around one line store and a small sequencer.
// ----------------------------------------------------------------------------
module console_line_editor_top #(
	parameter int BUF_DEPTH = cle_pkg::BUF_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_data,
	input  logic          req_valid,
	output logic          req_ready,
	input  cle_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output cle_pkg::rsp_t rsp
);
	import cle_pkg::*;

	localparam int SW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int PW = SW + 1;
	localparam logic [PW-1:0] POS_LAST = PW'(2 * BUF_DEPTH - 1);
	localparam logic [PW:0]   POS_MOD  = (PW+1)'(2 * BUF_DEPTH);
	localparam logic [PW:0]   DEPTH_W  = (PW+1)'(BUF_DEPTH);
	localparam logic [PW-1:0] DEPTH_P  = PW'(BUF_DEPTH);

	typedef enum logic [4:0] {
		S_IDLE     = 5'b00001,
		S_KILL_RD  = 5'b00010,
		S_KILL_CMP = 5'b00100,
		S_CONS     = 5'b01000,
		S_RESULT   = 5'b10000
	} state_t;

	function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] p);
		return (p == POS_LAST) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PW-1:0] pos_dec(input logic [PW-1:0] p);
		return (p == '0) ? POS_LAST : p - 1'b1;
	endfunction

	function automatic logic [PW:0] pos_diff(input logic [PW-1:0] a, input logic [PW-1:0] b);
		return (a >= b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + POS_MOD - {1'b0, b});
	endfunction

	function automatic logic [SW-1:0] pos_slot(input logic [PW-1:0] p);
		logic [PW-1:0] s;
		s = (p >= DEPTH_P) ? p - DEPTH_P : p;
		return s[SW-1:0];
	endfunction

	state_t        state_q;
	logic [PW-1:0] edit_q;
	logic [PW-1:0] read_q;
	logic [PW-1:0] commit_q;
	logic          cr_to_lf_q;
	rsp_t          res_q;
	rsp_t          rsp_q;
	logic          rsp_valid_q;

	logic [7:0]    line_mem [BUF_DEPTH];
	logic [7:0]    rd_data_q;
	logic [SW-1:0] rd_addr;

	logic          accept;
	logic          is_kill;
	logic          is_erase;
	logic          has_room;
	logic          is_cr;
	logic          keep;
	logic [7:0]    ch_st;
	logic [PW-1:0] edit_inc;
	logic [PW-1:0] edit_dec;
	logic [PW-1:0] edit_dec2;
	logic          commit_now;
	logic          store_en;
	logic          load_out;

	assign cfg_ready = 1'b1;
	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign load_out  = (state_q == S_RESULT) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		is_kill    = (req.ch == KEY_KILL);
		is_erase   = (req.ch == KEY_BS) || (req.ch == KEY_DEL);
		has_room   = pos_diff(edit_q, read_q) < DEPTH_W;
		is_cr      = (req.ch == KEY_CR);
		keep       = (req.ch != 8'h00) && !is_kill && !is_erase && has_room
			&& !(is_cr && !cr_to_lf_q);
		ch_st      = is_cr ? KEY_LF : req.ch;
		edit_inc   = pos_inc(edit_q);
		edit_dec   = pos_dec(edit_q);
		edit_dec2  = pos_dec(edit_dec);
		commit_now = (ch_st == KEY_LF) || (ch_st == KEY_EOF)
			|| (pos_diff(edit_inc, read_q) == DEPTH_W);
		store_en   = accept && (req.op == OP_RECV) && keep;
	end

	always_comb begin
		case (state_q)
			S_IDLE:     rd_addr = pos_slot(read_q);
			S_KILL_RD:  rd_addr = pos_slot(edit_dec);
			S_KILL_CMP: rd_addr = pos_slot(edit_dec2);
			default:    rd_addr = pos_slot(read_q);
		endcase
	end

	always_ff @(posedge clk) begin
		if (store_en) begin
			line_mem[pos_slot(edit_q)] <= ch_st;
		end
		rd_data_q <= line_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			edit_q      <= '0;
			read_q      <= '0;
			commit_q    <= '0;
			cr_to_lf_q  <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cr_to_lf_q <= cfg_data;
			end
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RESULT;
						if (req.op == OP_CONSUME) begin
							if (read_q != commit_q) begin
								read_q  <= pos_inc(read_q);
								state_q <= S_CONS;
							end
						end else if (is_kill) begin
							state_q <= S_KILL_RD;
						end else if (is_erase) begin
							if (edit_q != commit_q) begin
								edit_q <= edit_dec;
							end
						end else if (keep) begin
							edit_q <= edit_inc;
							if (commit_now) begin
								commit_q <= edit_inc;
							end
						end
					end
				end
				S_KILL_RD: begin
					state_q <= (edit_q == commit_q) ? S_RESULT : S_KILL_CMP;
				end
				S_KILL_CMP: begin
					if (rd_data_q == KEY_LF) begin
						state_q <= S_RESULT;
					end else begin
						edit_q <= edit_dec;
						if (edit_dec == commit_q) begin
							state_q <= S_RESULT;
						end
					end
				end
				S_CONS: begin
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (load_out) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			rsp_q <= res_q;
		end
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_q <= '0;
					if (req.op == OP_RECV) begin
						if (is_erase && !is_kill && (edit_q != commit_q)) begin
							res_q.erase_count <= 8'd1;
						end else if (!is_kill && !is_erase && keep) begin
							res_q.echo_valid <= 1'b1;
							res_q.echo_char  <= ch_st;
							res_q.line_ready <= commit_now;
						end
					end
				end
			end
			S_KILL_CMP: begin
				if ((rd_data_q != KEY_LF) && (res_q.erase_count != 8'hFF)) begin
					res_q.erase_count <= res_q.erase_count + 8'd1;
				end
			end
			S_CONS: begin
				res_q.read_valid <= 1'b1;
				if ((rd_data_q == KEY_LF) || (rd_data_q == KEY_EOF)) begin
					res_q.read_end <= 1'b1;
				end else begin
					res_q.read_byte <= rd_data_q;
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		pos_diff(edit_q, read_q) <= DEPTH_W)
		else $error("Uncommitted and committed bytes exceed the ring depth.");

	a_commit_order: assert property (@(posedge clk) disable iff (!arst_n)
		pos_diff(commit_q, read_q) <= pos_diff(edit_q, read_q))
		else $error("Commit position lies beyond the edit position.");

	a_kill_keeps_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_KILL_CMP) |=> $stable(commit_q) && $stable(read_q))
		else $error("Kill-line walk moved the commit or read position.");

	a_rsp_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.read_valid |-> !rsp.echo_valid && (rsp.erase_count == 8'd0))
		else $error("Read response also carries echo or erase information.");

	a_ready_echo: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.line_ready |-> rsp.echo_valid)
		else $error("Line committed without an echoed byte.");
`endif

endmodule

[tb/tb_console_line_editor_top.sv]
// ----------------------------------------------------------------------------
// Console line editor testbench
// Drives received bytes and consume requests into the line editor and compares
// every response with a cycle-free model of the line buffer or a table entry.
// A short table of directed items comes first, then random phases. Each sets
// the carriage return mode, then types edited lines, fills the ring, erases
// long lines or sends unshaped noise. Both sides of the block pause at random.
// ----------------------------------------------------------------------------
module tb_console_line_editor_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cle_pkg::*;

	localparam int DEPTH       = BUF_DEPTH_DEF;
	localparam int PW          = $clog2(2 * DEPTH);
	localparam int ITEM_TARGET = 1300;
	localparam int MAX_GAP     = 17;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 20;

	typedef struct {
		bit   cfg_row;
		bit   cfg_val;
		req_t item;
		bit   typed;
		rsp_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_data;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	logic [7:0]    line_mem [DEPTH];
	logic [PW-1:0] edit_ptr;
	logic [PW-1:0] read_ptr;
	logic [PW-1:0] commit_ptr;
	bit            cr_as_lf;

	rsp_t     due_rsp [$];
	dir_row_t dir_rows [$];
	bit       calm;
	int       errors;
	int       req_count;
	int       effect_count;
	int       rsp_count;
	int       cfg_count;
	int       full_commits;
	int       longest_kill;
	int       idle_cycles;

	console_line_editor_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int slot_of(input logic [PW-1:0] p);
		return int'(p) % DEPTH;
	endfunction

	function automatic rsp_t mk_rsp(input bit ev, input logic [7:0] ec, input logic [7:0] er,
			input bit lr, input bit rv, input logic [7:0] rb, input bit re);
		return {ev, ec, er, lr, rv, rb, re};
	endfunction

	// Applies one item to the line buffer and returns the response it causes.
	function automatic rsp_t edit_line(input req_t item);
		rsp_t          res;
		logic [7:0]    c;
		logic [7:0]    b;
		logic [PW-1:0] used;
		bit            keep;
		res = '0;
		c = item.ch;
		used = edit_ptr - read_ptr;
		if (item.op == OP_CONSUME) begin
			if (read_ptr != commit_ptr) begin
				b = line_mem[slot_of(read_ptr)];
				read_ptr = read_ptr + 1'b1;
				res.read_valid = 1'b1;
				if (b == KEY_LF || b == KEY_EOF)
					res.read_end = 1'b1;
				else
					res.read_byte = b;
			end
		end else if (c == KEY_KILL) begin
			while (edit_ptr != commit_ptr && line_mem[slot_of(edit_ptr - 1'b1)] != KEY_LF) begin
				edit_ptr = edit_ptr - 1'b1;
				if (res.erase_count != 8'd255)
					res.erase_count = res.erase_count + 8'd1;
			end
			if (res.erase_count > longest_kill)
				longest_kill = res.erase_count;
		end else if (c == KEY_BS || c == KEY_DEL) begin
			if (edit_ptr != commit_ptr) begin
				edit_ptr = edit_ptr - 1'b1;
				res.erase_count = 8'd1;
			end
		end else if (c != 8'h00 && used < DEPTH) begin
			keep = 1'b1;
			if (c == KEY_CR) begin
				if (cr_as_lf)
					c = KEY_LF;
				else
					keep = 1'b0;
			end
			if (keep) begin
				res.echo_valid = 1'b1;
				res.echo_char = c;
				line_mem[slot_of(edit_ptr)] = c;
				edit_ptr = edit_ptr + 1'b1;
				used = edit_ptr - read_ptr;
				if (c == KEY_LF || c == KEY_EOF || used == DEPTH) begin
					if (used == DEPTH)
						full_commits++;
					commit_ptr = edit_ptr;
					res.line_ready = 1'b1;
				end
			end
		end
		return res;
	endfunction

	function automatic int pick_gap();
		return calm ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (c == KEY_KILL || c == KEY_BS || c == KEY_DEL || c == KEY_EOF ||
			c == KEY_CR || c == KEY_LF);
		return c;
	endfunction

	task automatic add_req(input logic op, input logic [7:0] ch, input bit typed,
			input rsp_t want);
		dir_row_t row;
		row.cfg_row = 1'b0;
		row.cfg_val = 1'b0;
		row.item.op = op;
		row.item.ch = ch;
		row.typed = typed;
		row.want = want;
		dir_rows.push_back(row);
	endtask

	task automatic add_cfg(input bit val);
		dir_row_t row;
		row.cfg_row = 1'b1;
		row.cfg_val = val;
		row.item = '0;
		row.typed = 1'b0;
		row.want = '0;
		dir_rows.push_back(row);
	endtask

	task automatic send_req(input logic op, input logic [7:0] ch, input bit typed = 1'b0,
			input rsp_t want = '0);
		req_t item;
		rsp_t model_rsp;
		int   gap;
		item.op = op;
		item.ch = ch;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		model_rsp = edit_line(item);
		due_rsp.push_back(typed ? want : model_rsp);
		req_count++;
		if (model_rsp != '0)
			effect_count++;
	endtask

	task automatic write_cfg(input bit val);
		@(negedge clk);
		req_valid <= 1'b0;
		while (due_rsp.size() != 0) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cr_as_lf = val;
		cfg_count++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain_lines(input int extra);
		while (read_ptr != commit_ptr) send_req(OP_CONSUME, 8'($urandom));
		repeat (extra) send_req(OP_CONSUME, 8'($urandom));
	endtask

	task automatic type_lines();
		int roll;
		repeat ($urandom_range(2, 6)) begin
			repeat ($urandom_range(0, 24)) begin
				roll = $urandom_range(0, 99);
				if (roll < 6)
					send_req(OP_RECV, KEY_BS);
				else if (roll < 10)
					send_req(OP_RECV, KEY_DEL);
				else if (roll < 13)
					send_req(OP_RECV, KEY_KILL);
				else if (roll < 20)
					send_req(OP_CONSUME, 8'($urandom));
				else if (roll < 22)
					send_req(OP_RECV, 8'h00);
				else
					send_req(OP_RECV, plain_char());
			end
			roll = $urandom_range(0, 2);
			send_req(OP_RECV, roll == 0 ? KEY_LF : (roll == 1 ? KEY_CR : KEY_EOF));
			repeat ($urandom_range(0, 12)) send_req(OP_CONSUME, 8'($urandom));
		end
	endtask

	task automatic fill_ring();
		logic [PW-1:0] used;
		forever begin
			used = edit_ptr - read_ptr;
			if (used == DEPTH)
				break;
			send_req(OP_RECV, plain_char());
		end
		repeat ($urandom_range(2, 5))
			send_req(OP_RECV, $urandom_range(0, 1) ? plain_char() : KEY_LF);
		send_req(OP_RECV, KEY_BS);
		drain_lines($urandom_range(0, 2));
	endtask

	task automatic long_kill();
		int n;
		send_req(OP_RECV, KEY_LF);
		drain_lines(0);
		n = ($urandom_range(0, 3) == 0) ? DEPTH - 1 : $urandom_range(40, DEPTH - 1);
		repeat (n) send_req(OP_RECV, plain_char());
		send_req(OP_RECV, KEY_KILL);
		send_req(OP_RECV, KEY_KILL);
	endtask

	task automatic noise_burst();
		repeat ($urandom_range(20, 60))
			send_req(1'($urandom_range(0, 1)), 8'($urandom));
	endtask

	task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
		end
	endtask

	initial begin
		int stall;
		rsp_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = pick_gap();
			@(negedge clk);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			rsp_count++;
			if (due_rsp.size() == 0) begin
				errors++;
				$display("%0t: response expected none, got 0x%h", $time, rsp);
			end else begin
				want = due_rsp.pop_front();
				cmp_field("echo_valid", want.echo_valid, rsp.echo_valid);
				cmp_field("echo_char", want.echo_char, rsp.echo_char);
				cmp_field("erase_count", want.erase_count, rsp.erase_count);
				cmp_field("line_ready", want.line_ready, rsp.line_ready);
				cmp_field("read_valid", want.read_valid, rsp.read_valid);
				cmp_field("read_byte", want.read_byte, rsp.read_byte);
				cmp_field("read_end", want.read_end, rsp.read_end);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
				$display("Regression FAIL");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int mode;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		req_valid = 1'b0;
		req = '0;
		foreach (line_mem[i])
			line_mem[i] = 8'h00;
		edit_ptr = '0;
		read_ptr = '0;
		commit_ptr = '0;
		cr_as_lf = 1'b1;
		calm = 1'b0;

		add_req(OP_CONSUME, 8'hFF, 1'b1, '0);
		add_req(OP_RECV, 8'h00, 1'b1, '0);
		add_req(OP_RECV, KEY_BS, 1'b1, '0);
		add_req(OP_RECV, KEY_DEL, 1'b1, '0);
		add_req(OP_RECV, KEY_KILL, 1'b1, '0);
		add_req(OP_RECV, 8'h61, 1'b1, mk_rsp(1'b1, 8'h61, 8'd0, 1'b0, 1'b0, 8'h00, 1'b0));
		add_req(OP_RECV, 8'hFF, 1'b0, '0);
		add_req(OP_RECV, 8'h01, 1'b0, '0);
		add_req(OP_RECV, KEY_DEL, 1'b1, mk_rsp(1'b0, 8'h00, 8'd1, 1'b0, 1'b0, 8'h00, 1'b0));
		add_req(OP_RECV, KEY_CR, 1'b1, mk_rsp(1'b1, KEY_LF, 8'd0, 1'b1, 1'b0, 8'h00, 1'b0));
		add_req(OP_RECV, 8'h78, 1'b0, '0);
		add_req(OP_RECV, 8'h80, 1'b0, '0);
		add_req(OP_RECV, KEY_KILL, 1'b1, mk_rsp(1'b0, 8'h00, 8'd2, 1'b0, 1'b0, 8'h00, 1'b0));
		add_req(OP_RECV, 8'h7E, 1'b0, '0);
		add_req(OP_RECV, KEY_EOF, 1'b1, mk_rsp(1'b1, KEY_EOF, 8'd0, 1'b1, 1'b0, 8'h00, 1'b0));
		add_req(OP_CONSUME, 8'h00, 1'b1, mk_rsp(1'b0, 8'h00, 8'd0, 1'b0, 1'b1, 8'h61, 1'b0));
		add_req(OP_CONSUME, 8'h55, 1'b0, '0);
		add_req(OP_CONSUME, 8'hAA, 1'b1, mk_rsp(1'b0, 8'h00, 8'd0, 1'b0, 1'b1, 8'h00, 1'b1));
		add_req(OP_CONSUME, 8'h00, 1'b0, '0);
		add_req(OP_CONSUME, 8'h00, 1'b1, mk_rsp(1'b0, 8'h00, 8'd0, 1'b0, 1'b1, 8'h00, 1'b1));
		add_req(OP_CONSUME, 8'h00, 1'b1, '0);
		add_req(OP_RECV, KEY_LF, 1'b1, mk_rsp(1'b1, KEY_LF, 8'd0, 1'b1, 1'b0, 8'h00, 1'b0));
		add_req(OP_CONSUME, 8'h00, 1'b1, mk_rsp(1'b0, 8'h00, 8'd0, 1'b0, 1'b1, 8'h00, 1'b1));
		add_cfg(1'b0);
		add_req(OP_RECV, KEY_CR, 1'b1, '0);
		add_req(OP_RECV, KEY_BS, 1'b1, '0);

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].cfg_row)
				write_cfg(dir_rows[i].cfg_val);
			else
				send_req(dir_rows[i].item.op, dir_rows[i].item.ch, dir_rows[i].typed,
					dir_rows[i].want);
		end

		while (req_count < ITEM_TARGET) begin
			write_cfg(1'($urandom_range(0, 1)));
			calm = ($urandom_range(0, 3) == 0);
			mode = $urandom_range(0, 9);
			if (mode < 5)
				type_lines();
			else if (mode < 7)
				fill_ring();
			else if (mode < 8)
				long_kill();
			else
				noise_burst();
		end
		drain_lines(1);

		@(negedge clk);
		req_valid <= 1'b0;
		while (due_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Ran %0d request transfers (%0d with an effect), checked %0d responses,",
			req_count, effect_count, rsp_count);
		$display("wrote the mode %0d times; the ring filled and committed %0d times;",
			cfg_count, full_commits);
		$display("the longest line kill erased %0d bytes.", longest_kill);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
